@@ src/rxft_pkg.sv @@
// ----------------------------------------------------------------------------
// rxft_pkg
// Shared types and constants for the receive FIFO idle-timeout framer.
// ----------------------------------------------------------------------------
`default_nettype none

package rxft_pkg;

    localparam logic [1:0] OP_RX   = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [7:0] IDLE_RESET = 8'd5;
    localparam logic [7:0] FULL_TIMER = 8'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_data;
        logic       rx_dropped;
        logic       frame_ready;
        logic [7:0] frame_count;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ src/rxft_ctrl.sv @@
// ----------------------------------------------------------------------------
// rxft_ctrl
// Sequencer: capture a transfer, execute it, then load the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rxft_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire rxft_pkg::ctrl_status_t status,
    output rxft_pkg::ctrl_cmd_t        cmd
);
    import rxft_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   in_stall_next;

    always_comb
    begin
        state_next    = state_reg;
        in_stall_next = in_stall_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = ST_EXEC;
                    in_stall_next = 1'b1;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next    = ST_IDLE;
                    in_stall_next = 1'b0;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall     = in_stall_reg;
    assign cmd.capture  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.execute  = (state_reg == ST_EXEC);
    assign cmd.load_out = (state_reg == ST_DONE) && status.out_free;

endmodule

`default_nettype wire

@@ src/rxft_datapath.sv @@
// ----------------------------------------------------------------------------
// rxft_datapath
// Ring buffer, indexes, fill count, idle timer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rxft_datapath
#(
    parameter int DEPTH = 128
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rxft_pkg::in_item_t   in_data,
    input  wire logic [7:0]           idle_ticks,
    input  wire rxft_pkg::ctrl_cmd_t  cmd,
    output rxft_pkg::ctrl_status_t    status,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output rxft_pkg::out_item_t       out_data
);
    import rxft_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW-1:0] ALMOST    = CW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;

    logic [1:0]    op_reg;
    logic [7:0]    byte_reg;
    logic [AW-1:0] wr_idx_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [CW-1:0] count_reg;
    logic [7:0]    timer_reg;

    logic          res_valid_reg;
    logic          res_drop_reg;
    logic          res_ready_reg;
    logic [7:0]    res_count_reg;

    out_item_t     out_reg;
    logic          out_valid_reg;

    logic          do_write;
    logic          do_read;
    logic          do_tick;

    assign do_write = cmd.execute && (op_reg == OP_RX) && (count_reg != FULL_CNT);
    assign do_read  = cmd.execute && (op_reg == OP_READ) && (count_reg != '0);
    assign do_tick  = cmd.execute && (op_reg == OP_TICK) && (timer_reg != 8'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_data.op;
            byte_reg <= in_data.rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_idx_reg] <= byte_reg;
        end
        if (do_read)
        begin
            rdata_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
            timer_reg  <= 8'd0;
        end
        else
        begin
            if (do_write)
            begin
                wr_idx_reg <= (wr_idx_reg == LAST_SLOT) ? '0 : wr_idx_reg + 1'b1;
                count_reg  <= count_reg + 1'b1;
                timer_reg  <= (count_reg == ALMOST) ? FULL_TIMER : idle_ticks;
            end
            else if (do_read)
            begin
                rd_idx_reg <= (rd_idx_reg == LAST_SLOT) ? '0 : rd_idx_reg + 1'b1;
                count_reg  <= count_reg - 1'b1;
            end
            else if (do_tick)
            begin
                timer_reg <= timer_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            res_valid_reg <= do_read;
            res_drop_reg  <= (op_reg == OP_RX) && (count_reg == FULL_CNT);
            res_ready_reg <= do_tick && (timer_reg == 8'd1);
            res_count_reg <= (do_tick && (timer_reg == 8'd1)) ? 8'(count_reg) : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.read_valid  <= res_valid_reg;
            out_reg.read_data   <= res_valid_reg ? rdata_reg : 8'd0;
            out_reg.rx_dropped  <= res_drop_reg;
            out_reg.frame_ready <= res_ready_reg;
            out_reg.frame_count <= res_count_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

`default_nettype wire

@@ src/rx_fifo_idle_timeout_framer.sv @@
// An input transfer is captured, executed into the result registers, then loaded into the output register.
// Items are handled one at a time (capture, execute with buffer access, result load);
// the single-port buffer read is registered, which sets the execute-to-result step.
// An output stall holds the result load, and with it the next input, until the register frees.
// Reset: rst_n is asynchronous, active low; buffer empty, idle timer zero, idle_ticks 5.
// Buffer contents are not cleared by reset.
// ----------------------------------------------------------------------------
// rx_fifo_idle_timeout_framer
// Receive FIFO that flags a frame after a programmable idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_fifo_idle_timeout_framer
#(
    parameter int DEPTH = 128
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire rxft_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output rxft_pkg::out_item_t      out_data
);
    import rxft_pkg::*;

    logic         [7:0] idle_ticks_reg;
    ctrl_cmd_t          cmd;
    ctrl_status_t       status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg <= IDLE_RESET;
        end
        else if (cfg_we)
        begin
            idle_ticks_reg <= cfg_wdata;
        end
    end

    rxft_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rxft_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .idle_ticks (idle_ticks_reg),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

@@ bench/rx_fifo_idle_timeout_framer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_fifo_idle_timeout_framer_tb
// Drives receive, read, tick and unused-op transfers into the framer with
// random gaps and output stalls. A cycle-free model of the buffer and the
// idle timer predicts every result, and each output transfer is checked
// field by field in order. The idle reload is changed between phases while
// the block is quiet, covering 0, 1, 255 and random values, a full-buffer
// pass with drops, and a final stretch with no idling at all.
// ----------------------------------------------------------------------------

module rx_fifo_idle_timeout_framer_tb;

    import rxft_pkg::*;

    localparam int         FIFO_DEPTH = 128;
    localparam logic [1:0] OP_NONE    = 2'd3;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;

    // buffer and timer model
    logic [7:0] byte_mem [FIFO_DEPTH];
    logic [6:0] wr_ptr;
    logic [6:0] rd_ptr;
    logic [7:0] fill_lvl;
    logic [7:0] idle_tmr;
    logic [7:0] idle_cfg;

    in_item_t   host_ops[$];
    out_item_t  framer_answers[$];

    int         bad_fields = 0;
    bit         quiet = 1'b0;
    int         gap_left;
    int         stall_left;

    rx_fifo_idle_timeout_framer #(
        .DEPTH     (FIFO_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic out_item_t framer_step(input in_item_t it);
        out_item_t r;
        r = '0;
        case (it.op)
            OP_RX:
            begin
                if (fill_lvl < FIFO_DEPTH)
                begin
                    byte_mem[wr_ptr] = it.rx_byte;
                    wr_ptr   = wr_ptr + 7'd1;
                    fill_lvl = fill_lvl + 8'd1;
                    idle_tmr = (fill_lvl == FIFO_DEPTH) ? FULL_TIMER : idle_cfg;
                end
                else
                begin
                    r.rx_dropped = 1'b1;
                end
            end
            OP_READ:
            begin
                if (fill_lvl != 8'd0)
                begin
                    r.read_valid = 1'b1;
                    r.read_data  = byte_mem[rd_ptr];
                    rd_ptr   = rd_ptr + 7'd1;
                    fill_lvl = fill_lvl - 8'd1;
                end
            end
            OP_TICK:
            begin
                if (idle_tmr != 8'd0)
                begin
                    idle_tmr = idle_tmr - 8'd1;
                    if (idle_tmr == 8'd0)
                    begin
                        r.frame_ready = 1'b1;
                        r.frame_count = fill_lvl;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_bad(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        if (bad_fields < 100)
            $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        bad_fields++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                framer_answers.push_back(framer_step(in_data));
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (host_ops.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= host_ops.pop_front();
                    if (!quiet && $urandom_range(0, 9) == 0)
                        gap_left <= $urandom_range(1, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (framer_answers.size() == 0)
                begin
                    report_bad("unexpected transfer", 32'(out_data), 32'd0);
                end
                else
                begin
                    want = framer_answers.pop_front();
                    if (out_data.read_valid !== want.read_valid)
                        report_bad("read_valid", 32'(out_data.read_valid),
                                   32'(want.read_valid));
                    if (out_data.read_data !== want.read_data)
                        report_bad("read_data", 32'(out_data.read_data),
                                   32'(want.read_data));
                    if (out_data.rx_dropped !== want.rx_dropped)
                        report_bad("rx_dropped", 32'(out_data.rx_dropped),
                                   32'(want.rx_dropped));
                    if (out_data.frame_ready !== want.frame_ready)
                        report_bad("frame_ready", 32'(out_data.frame_ready),
                                   32'(want.frame_ready));
                    if (out_data.frame_count !== want.frame_count)
                        report_bad("frame_count", 32'(out_data.frame_count),
                                   32'(want.frame_count));
                end
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 9);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_op(input logic [1:0] op, input logic [7:0] b);
        in_item_t it;
        it.op      = op;
        it.rx_byte = b;
        host_ops.push_back(it);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (host_ops.size() != 0 || in_valid || framer_answers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idle(input logic [7:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        idle_cfg   = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // mostly frames: bytes, ticks up to expiry (sometimes cut short), reads
    task automatic random_traffic(input int n);
        int sent;
        int k;
        int t;
        int r;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(1, 12);
                repeat (k) push_op(OP_RX, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                    t = $urandom_range(0, idle_cfg);
                else
                    t = idle_cfg + $urandom_range(0, 2);
                repeat (t) push_op(OP_TICK, 8'($urandom_range(0, 255)));
                r = $urandom_range(0, k + 1);
                repeat (r) push_op(OP_READ, 8'($urandom_range(0, 255)));
                sent += k + t + r;
            end
            else
            begin
                k = $urandom_range(1, 4);
                repeat (k) push_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                sent += k;
            end
        end
    endtask

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        wr_ptr   = '0;
        rd_ptr   = '0;
        fill_lvl = '0;
        idle_tmr = '0;
        idle_cfg = IDLE_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset reload value
        push_op(OP_READ, 8'h00);
        push_op(OP_TICK, 8'hFF);
        push_op(OP_NONE, 8'hFF);
        push_op(OP_RX, 8'h00);
        push_op(OP_RX, 8'hFF);
        push_op(OP_NONE, 8'h00);
        push_op(OP_RX, 8'hA5);
        repeat (6) push_op(OP_TICK, 8'h00);
        repeat (4) push_op(OP_READ, 8'h5A);
        push_op(OP_TICK, 8'h00);
        wait_drained();

        set_idle(8'd1);
        random_traffic(80);
        wait_drained();

        // full buffer: timer forced to 1, drops leave it alone
        set_idle(8'd255);
        repeat (fill_lvl) push_op(OP_READ, 8'h00);
        repeat (FIFO_DEPTH + 2) push_op(OP_RX, 8'($urandom_range(0, 255)));
        repeat (2) push_op(OP_TICK, 8'h00);
        repeat (FIFO_DEPTH + 1) push_op(OP_READ, 8'h00);
        repeat (2) push_op(OP_RX, 8'($urandom_range(0, 255)));
        repeat (8) push_op(OP_TICK, 8'h00);
        repeat (2) push_op(OP_READ, 8'h00);
        wait_drained();

        set_idle(8'd0);
        random_traffic(40);
        wait_drained();

        set_idle(8'($urandom_range(2, 12)));
        random_traffic(80);
        wait_drained();

        set_idle(8'($urandom_range(1, 8)));
        quiet = 1'b1;
        random_traffic(80);
        wait_drained();
        repeat (10) @(negedge clk);

        if (bad_fields == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
